### rtl/core/cgnc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cell grid neighbour counter package
// Shared field widths, request codes, controller states and the command and
// status records that pass between the controller and the datapath, and the neighbour offsets.
// ----------------------------------------------------------------------------
package cgnc_pkg;

   // Field widths of the request and response transactions.
   localparam int FUNC_W     = 3;
   localparam int COORD_W    = 6;
   localparam int DIM_W      = 7;
   localparam int CNT_W      = 4;
   localparam int REQ_W      = 16;
   localparam int RSP_W      = 8;
   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 7;
   localparam int STEP_W     = 3;
   localparam int IDX_W      = 2 * DIM_W + 1;

   // Number of Moore neighbours around one cell.
   localparam int NB_COUNT   = 8;
   localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(NB_COUNT - 1);

   // Configuration register indexes.
   localparam logic [CSR_ADDR_W-1:0] CSR_WALLS  = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_WIDTH  = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_HEIGHT = 2'd2;

   // Request function codes.
   typedef enum logic [FUNC_W-1:0] {
      FUNC_SET      = 3'd0,
      FUNC_TOGGLE   = 3'd1,
      FUNC_ALL_LIVE = 3'd2,
      FUNC_ALL_DEAD = 3'd3,
      FUNC_READ     = 3'd4,
      FUNC_COUNT    = 3'd5
   } func_type;

   // Controller states.
   typedef enum logic [3:0] {
      ST_INIT,
      ST_IDLE,
      ST_READ,
      ST_EVAL,
      ST_COUNT,
      ST_DRAIN1,
      ST_DRAIN2,
      ST_SWEEP,
      ST_DONE
   } state_type;

   // Offset of a neighbour along one axis.
   typedef enum logic [1:0] {
      OFF_NEG,
      OFF_ZERO,
      OFF_POS
   } off_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic                load;
      logic                eval;
      logic                write;
      logic                nb_step;
      logic [STEP_W-1:0]   step;
      logic                sweep;
      logic                push;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      func_type            req_func;
      logic                req_oor;
      func_type            func;
      logic                sweep_last;
   } status_type;

   // Row offset of the neighbour visited at a given step.
   function automatic off_type nb_row_off(input logic [STEP_W-1:0] step);
      off_type off;
      case (step)
         3'd0, 3'd1, 3'd2: off = OFF_NEG;
         3'd3, 3'd4:       off = OFF_ZERO;
         default:          off = OFF_POS;
      endcase
      return off;
   endfunction

   // Column offset of the neighbour visited at a given step.
   function automatic off_type nb_col_off(input logic [STEP_W-1:0] step);
      off_type off;
      case (step)
         3'd0, 3'd3, 3'd5: off = OFF_NEG;
         3'd1, 3'd6:       off = OFF_ZERO;
         default:          off = OFF_POS;
      endcase
      return off;
   endfunction

endpackage

### rtl/core/cgnc_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic single-port RAM
// One address shared by write and read; the read data is registered.
// ----------------------------------------------------------------------------
module cgnc_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 4096,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    addr,
   input  logic [WIDTH-1:0] wr_data,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write and registered read at the same address.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/core/cgnc_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cell grid neighbour counter controller
// Sequences each request through the datapath and owns both handshakes.
// ----------------------------------------------------------------------------
module cgnc_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   input  cgnc_pkg::status_type status,
   output cgnc_pkg::cmd_type    cmd
);
   import cgnc_pkg::*;

   state_type         state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              rsp_tvalid_ff, rsp_tvalid_in;
   logic              accept;
   logic              out_free;
   logic              push;
   logic              is_sweep_func;
   logic              is_cell_func;

   assign accept   = req_tvalid && req_tready;
   assign out_free = !rsp_tvalid_ff || rsp_tready;
   assign push     = (state_ff == ST_DONE) && out_free;

   // Classify the incoming request.
   always_comb begin
      is_sweep_func = 1'b0;
      is_cell_func  = 1'b0;
      case (status.req_func)
         FUNC_ALL_LIVE, FUNC_ALL_DEAD: is_sweep_func = 1'b1;
         FUNC_SET, FUNC_TOGGLE, FUNC_READ, FUNC_COUNT: is_cell_func = 1'b1;
         default: ;
      endcase
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_INIT: begin
            if (status.sweep_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (accept) begin
               if (is_sweep_func) begin
                  state_in = ST_SWEEP;
               end else if (is_cell_func && !status.req_oor) begin
                  state_in = ST_READ;
               end else begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_READ: state_in = ST_EVAL;
         ST_EVAL: begin
            state_in = (status.func == FUNC_COUNT) ? ST_COUNT : ST_DONE;
         end
         ST_COUNT: begin
            if (step_ff == LAST_STEP) state_in = ST_DRAIN1;
         end
         ST_DRAIN1: state_in = ST_DRAIN2;
         ST_DRAIN2: state_in = ST_DONE;
         ST_SWEEP: begin
            if (status.sweep_last) state_in = ST_DONE;
         end
         ST_DONE: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Commands and handshake outputs.
   always_comb begin
      req_tready  = (state_ff == ST_IDLE);
      cmd.load    = accept;
      cmd.eval    = (state_ff == ST_EVAL);
      cmd.write   = (state_ff == ST_EVAL) &&
                    ((status.func == FUNC_SET) || (status.func == FUNC_TOGGLE));
      cmd.nb_step = (state_ff == ST_COUNT);
      cmd.step    = step_ff;
      cmd.sweep   = (state_ff == ST_SWEEP) || (state_ff == ST_INIT);
      cmd.push    = push;
   end

   // Neighbour step counter and response valid flag.
   always_comb begin
      step_in = (state_ff == ST_COUNT) ? step_ff + 1'b1 : '0;
      if (push) begin
         rsp_tvalid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_tvalid_in = 1'b0;
      end else begin
         rsp_tvalid_in = rsp_tvalid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_INIT;
         step_ff       <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         step_ff       <= step_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;

`ifndef SYNTHESIS
   // A new response only ever follows the done state.
   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid_ff) |-> $past(state_ff == ST_DONE))
      else $error("response raised outside the done state");

   // The drain phase starts only after all eight neighbours were issued.
   a_all_steps: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DRAIN1) |-> $past(state_ff == ST_COUNT && step_ff == LAST_STEP))
      else $error("neighbour scan ended early");

   // A fill leaves the sweep only at the last address.
   a_sweep_end: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SWEEP) && (state_in != ST_SWEEP) |-> status.sweep_last)
      else $error("fill sweep ended before the last address");
`endif

endmodule

### rtl/core/cgnc_dpath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cell grid neighbour counter datapath
// Holds the configuration, the request, the address unit, the result
// registers and the response register, and drives the cell store port.
// ----------------------------------------------------------------------------
module cgnc_dpath #(
   parameter int MAX_COLS = 64,
   parameter int MAX_ROWS = 64,
   parameter int DEPTH    = MAX_COLS * MAX_ROWS,
   parameter int AW       = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_we,
   input  logic [cgnc_pkg::CSR_ADDR_W-1:0] csr_addr,
   input  logic [cgnc_pkg::CSR_DATA_W-1:0] csr_wdata,
   input  logic [cgnc_pkg::REQ_W-1:0]    req_tdata,
   output logic [cgnc_pkg::RSP_W-1:0]    rsp_tdata,
   input  cgnc_pkg::cmd_type             cmd,
   output cgnc_pkg::status_type          status,
   output logic                          ram_we,
   output logic [AW-1:0]                 ram_addr,
   output logic                          ram_wdata,
   input  logic                          ram_rdata
);
   import cgnc_pkg::*;

   localparam int ResetCols = (MAX_COLS < 64) ? MAX_COLS : 64;
   localparam int ResetRows = (MAX_ROWS < 64) ? MAX_ROWS : 64;
   localparam logic [AW-1:0] LastAddr = AW'(DEPTH - 1);

   // Configuration, held as effective (saturated) sizes.
   logic               walls_ff, walls_in;
   logic [DIM_W-1:0]   eff_w_ff, eff_w_in;
   logic [DIM_W-1:0]   eff_h_ff, eff_h_in;

   // Request fields.
   func_type           req_func;
   logic [COORD_W-1:0] req_col;
   logic [COORD_W-1:0] req_row;
   logic               req_value;
   logic               req_cell;
   logic               req_oor;

   func_type           func_ff;
   logic [COORD_W-1:0] col_ff;
   logic [COORD_W-1:0] row_ff;
   logic               value_ff;

   // Address unit.
   off_type            col_off;
   off_type            row_off;
   logic [DIM_W-1:0]   nb_col;
   logic [DIM_W-1:0]   nb_row;
   logic               off_col;
   logic               off_row;
   logic [DIM_W-1:0]   mul_row;
   logic [DIM_W-1:0]   mul_col;
   logic [2*DIM_W-1:0] prod;
   logic [IDX_W-1:0]   idx;
   logic [AW-1:0]      addr_ff;
   logic               nb_use_ff;
   logic               nb_pend_ff;

   // Fill sweep.
   logic [AW-1:0]      sweep_ff;
   logic               sweep_val_ff;

   // Results.
   logic               new_bit;
   logic               alive_ff;
   logic [CNT_W-1:0]   cnt_ff;
   logic               oor_ff;
   logic [RSP_W-1:0]   rsp_tdata_ff;

   // Unpack the request transaction.
   assign req_func  = func_type'(req_tdata[FUNC_W-1:0]);
   assign req_col   = req_tdata[FUNC_W +: COORD_W];
   assign req_row   = req_tdata[FUNC_W+COORD_W +: COORD_W];
   assign req_value = req_tdata[FUNC_W+2*COORD_W];

   // Range check for requests that address a single cell.
   always_comb begin
      case (req_func)
         FUNC_SET, FUNC_TOGGLE, FUNC_READ, FUNC_COUNT: req_cell = 1'b1;
         default: req_cell = 1'b0;
      endcase
      req_oor = req_cell && ((DIM_W'(req_col) >= eff_w_ff) ||
                             (DIM_W'(req_row) >= eff_h_ff));
   end

   assign status.req_func   = req_func;
   assign status.req_oor    = req_oor;
   assign status.func       = func_ff;
   assign status.sweep_last = (sweep_ff == LastAddr);

   // Configuration writes saturate the sizes to the store dimensions.
   always_comb begin
      walls_in = walls_ff;
      eff_w_in = eff_w_ff;
      eff_h_in = eff_h_ff;
      if (csr_we) begin
         case (csr_addr)
            CSR_WALLS:  walls_in = csr_wdata[0];
            CSR_WIDTH:  eff_w_in = (int'(csr_wdata) > MAX_COLS) ? DIM_W'(MAX_COLS)
                                                                : csr_wdata;
            CSR_HEIGHT: eff_h_in = (int'(csr_wdata) > MAX_ROWS) ? DIM_W'(MAX_ROWS)
                                                                : csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         walls_ff <= 1'b0;
         eff_w_ff <= DIM_W'(ResetCols);
         eff_h_ff <= DIM_W'(ResetRows);
      end else begin
         walls_ff <= walls_in;
         eff_w_ff <= eff_w_in;
         eff_h_ff <= eff_h_in;
      end
   end

   // Neighbour coordinates: wrap on the torus, flag when off the grid.
   always_comb begin
      col_off = nb_col_off(cmd.step);
      row_off = nb_row_off(cmd.step);
      nb_col  = DIM_W'(col_ff);
      off_col = 1'b0;
      case (col_off)
         OFF_NEG: begin
            if (col_ff == '0) begin
               nb_col  = eff_w_ff - 1'b1;
               off_col = 1'b1;
            end else begin
               nb_col = DIM_W'(col_ff) - 1'b1;
            end
         end
         OFF_POS: begin
            if (DIM_W'(col_ff) + 1'b1 >= eff_w_ff) begin
               nb_col  = '0;
               off_col = 1'b1;
            end else begin
               nb_col = DIM_W'(col_ff) + 1'b1;
            end
         end
         default: ;
      endcase
      nb_row  = DIM_W'(row_ff);
      off_row = 1'b0;
      case (row_off)
         OFF_NEG: begin
            if (row_ff == '0) begin
               nb_row  = eff_h_ff - 1'b1;
               off_row = 1'b1;
            end else begin
               nb_row = DIM_W'(row_ff) - 1'b1;
            end
         end
         OFF_POS: begin
            if (DIM_W'(row_ff) + 1'b1 >= eff_h_ff) begin
               nb_row  = '0;
               off_row = 1'b1;
            end else begin
               nb_row = DIM_W'(row_ff) + 1'b1;
            end
         end
         default: ;
      endcase
   end

   // Row-major index, one multiplier shared by the center and the neighbours.
   always_comb begin
      mul_row = cmd.load ? DIM_W'(req_row) : nb_row;
      mul_col = cmd.load ? DIM_W'(req_col) : nb_col;
      prod    = mul_row * eff_w_ff;
      idx     = IDX_W'(prod) + IDX_W'(mul_col);
   end

   // Value written back by set and toggle, also the reported cell state.
   always_comb begin
      case (func_ff)
         FUNC_SET:    new_bit = value_ff;
         FUNC_TOGGLE: new_bit = !ram_rdata;
         default:     new_bit = ram_rdata;
      endcase
   end

   // Request, address and result registers.
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         func_ff  <= req_func;
         col_ff   <= req_col;
         row_ff   <= req_row;
         value_ff <= req_value;
         oor_ff   <= req_oor;
      end
      if (cmd.load || cmd.nb_step) begin
         addr_ff <= AW'(idx);
      end
      if (cmd.load) begin
         alive_ff <= 1'b0;
      end else if (cmd.eval) begin
         alive_ff <= new_bit;
      end
      if (cmd.load) begin
         cnt_ff <= '0;
      end else if (nb_pend_ff && ram_rdata) begin
         cnt_ff <= cnt_ff + 1'b1;
      end
      if (cmd.push) begin
         rsp_tdata_ff <= RSP_W'({oor_ff, cnt_ff, alive_ff});
      end
   end

   // Read pipeline flags for the neighbour scan, and the fill sweep.
   always_ff @(posedge clock) begin
      if (reset) begin
         nb_use_ff    <= 1'b0;
         nb_pend_ff   <= 1'b0;
         sweep_ff     <= '0;
         sweep_val_ff <= 1'b0;
      end else begin
         nb_use_ff  <= cmd.nb_step && !(walls_ff && (off_col || off_row));
         nb_pend_ff <= nb_use_ff;
         if (cmd.load) begin
            sweep_ff     <= '0;
            sweep_val_ff <= (req_func == FUNC_ALL_LIVE);
         end else if (cmd.sweep) begin
            sweep_ff <= (sweep_ff == LastAddr) ? '0 : sweep_ff + 1'b1;
         end
      end
   end

   // Cell store port.
   assign ram_we    = cmd.sweep || cmd.write;
   assign ram_addr  = cmd.sweep ? sweep_ff : addr_ff;
   assign ram_wdata = cmd.sweep ? sweep_val_ff : new_bit;
   assign rsp_tdata = rsp_tdata_ff;

`ifndef SYNTHESIS
   // The neighbour count never exceeds the size of the neighbourhood.
   a_cnt_max: assert property (@(posedge clock) disable iff (reset)
      cmd.push |-> (int'(cnt_ff) <= NB_COUNT))
      else $error("neighbour count above eight");

   // An ignored request reports no cell state and no count.
   a_oor_zero: assert property (@(posedge clock) disable iff (reset)
      cmd.push && oor_ff |-> !alive_ff && (cnt_ff == '0))
      else $error("out-of-range request reported data");
`endif

endmodule

### rtl/core/cell_grid_neighbour_counter.sv
`timescale 1ns / 1ps
// Set, toggle and read pass through a store read and an evaluate step before the response;
// a neighbour count adds eight reads through the single store port; an ignored request
// goes straight to the response. A new request is taken only once the last response
// is in the response register; all-live and all-dead sweep the store one cell a cycle.
// Reset is synchronous; afterwards a clearing pass over the whole store runs
// before the first request is accepted. Configuration writes are taken at any time.
// ----------------------------------------------------------------------------
// Cell grid neighbour counter
// Bit grid of live cells with single-cell set, toggle and read, whole-grid
// fill, and Moore neighbour counting with walls or toroidal wrap.
// ----------------------------------------------------------------------------
module cell_grid_neighbour_counter #(
   parameter int MAX_COLS = 64,
   parameter int MAX_ROWS = 64
) (
   input  logic                            clock,
   input  logic                            reset,
   // Configuration write port.
   input  logic                            csr_we,
   input  logic [cgnc_pkg::CSR_ADDR_W-1:0] csr_addr,
   input  logic [cgnc_pkg::CSR_DATA_W-1:0] csr_wdata,
   // Request channel.
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [cgnc_pkg::REQ_W-1:0]      req_tdata,  // func, col, row, value
   // Response channel.
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [cgnc_pkg::RSP_W-1:0]      rsp_tdata   // cell_alive, neighbour_count,
                                                       // out_of_range
);
   import cgnc_pkg::*;

   localparam int Depth = MAX_COLS * MAX_ROWS;
   localparam int Aw    = (Depth > 1) ? $clog2(Depth) : 1;

   cmd_type    cmd;
   status_type status;
   logic          ram_we;
   logic [Aw-1:0] ram_addr;
   logic          ram_wdata;
   logic          ram_rdata;

   // Request sequencing.
   cgnc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   // Address unit, results and configuration.
   cgnc_dpath #(
      .MAX_COLS (MAX_COLS),
      .MAX_ROWS (MAX_ROWS),
      .DEPTH    (Depth),
      .AW       (Aw)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .req_tdata (req_tdata),
      .rsp_tdata (rsp_tdata),
      .cmd       (cmd),
      .status    (status),
      .ram_we    (ram_we),
      .ram_addr  (ram_addr),
      .ram_wdata (ram_wdata),
      .ram_rdata (ram_rdata)
   );

   // Cell store.
   cgnc_ram #(
      .WIDTH (1),
      .DEPTH (Depth),
      .AW    (Aw)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .addr    (ram_addr),
      .wr_data (ram_wdata),
      .rd_data (ram_rdata)
   );

endmodule

### tb/sv/tb_cell_grid_neighbour_counter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cell grid neighbour counter testbench
// Drives set, toggle, fill, read and neighbour-count requests into the block
// and keeps its own copy of the cell grid and the registers. Each response is
// checked field by field against the oldest predicted one. A short table of
// directed requests covers edges, unused codes, out-of-range coordinates and
// tiny wrapped grids. Random phases follow under changing grid sizes, with
// bursts of idle cycles on both channels and one long response hold-off.
// ----------------------------------------------------------------------------
module tb_cell_grid_neighbour_counter;
   import cgnc_pkg::*;

   localparam int MAX_COLS        = 64;
   localparam int MAX_ROWS        = 64;
   localparam int NUM_PHASES      = 12;
   localparam int ITEMS_PER_PHASE = 75;
   localparam int PRESET_PHASES   = 6;
   localparam int PRESSURE_PHASE  = 2;
   localparam int HOLD_CYCLES     = 300;
   localparam int SETTLE_CYCLES   = 20;
   // Long enough to cover a sweep or the clearing pass after reset.
   localparam int QUIET_LIMIT     = 20000;

   // Function codes the block does not define; it answers them with zeros.
   localparam logic [FUNC_W-1:0] FUNC_SPARE_6 = 3'd6;
   localparam logic [FUNC_W-1:0] FUNC_SPARE_7 = 3'd7;

   // Grid settings of the first random phases: extremes and saturation.
   localparam logic       PRESET_WALLS [PRESET_PHASES] = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1};
   localparam logic [6:0] PRESET_COLS  [PRESET_PHASES] = '{7'd64, 7'd1, 7'd2, 7'd127, 7'd0, 7'd64};
   localparam logic [6:0] PRESET_ROWS  [PRESET_PHASES] = '{7'd64, 7'd64, 7'd1, 7'd127, 7'd127, 7'd0};

   // Request fields, func in the lowest bits.
   typedef struct packed {
      logic               value;
      logic [COORD_W-1:0] row;
      logic [COORD_W-1:0] col;
      logic [FUNC_W-1:0]  func;
   } grid_request_type;

   // Response fields, alive in the lowest bits.
   typedef struct packed {
      logic             oor;
      logic [CNT_W-1:0] count;
      logic             alive;
   } grid_result_type;

   // One line of the directed table: a grid setting or a request.
   typedef struct packed {
      logic             is_cfg;
      logic             walls;
      logic [DIM_W-1:0] cols;
      logic [DIM_W-1:0] rows;
      grid_request_type req;
      logic             typed;
      grid_result_type  given;
   } plan_row_type;

   logic                  clock;
   logic                  reset;
   logic                  csr_we;
   logic [CSR_ADDR_W-1:0] csr_addr;
   logic [CSR_DATA_W-1:0] csr_wdata;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_W-1:0]      req_tdata;   // func, col, row, value
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_W-1:0]      rsp_tdata;   // cell_alive, neighbour_count, out_of_range

   // Mirror of the block's grid and registers.
   bit               grid_cells [MAX_COLS * MAX_ROWS];
   logic             walls_on;
   logic [DIM_W-1:0] width_reg;
   logic [DIM_W-1:0] height_reg;

   grid_result_type pending_results [$];
   int              fail_count;
   int              gap_pct;
   int              stall_pct;
   bit              stall_hold;

   cell_grid_neighbour_counter #(
      .MAX_COLS(MAX_COLS),
      .MAX_ROWS(MAX_ROWS)
   ) DUT (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // Clock generation.
   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Live cells among the eight Moore neighbours, each position counted on its own.
   function automatic int live_neighbours(int col, int row, int w, int h);
      int total;
      int nc;
      int nr;
      total = 0;
      for (int dr = -1; dr <= 1; dr++) begin
         for (int dc = -1; dc <= 1; dc++) begin
            if (dr == 0 && dc == 0) continue;
            nr = row + dr;
            nc = col + dc;
            if (walls_on) begin
               if (nc < 0 || nc >= w || nr < 0 || nr >= h) continue;
            end else begin
               nc = ((nc % w) + w) % w;
               nr = ((nr % h) + h) % h;
            end
            total += grid_cells[nr * w + nc];
         end
      end
      return total;
   endfunction

   // Applies one request to the mirrored grid and returns the response it must give.
   function automatic grid_result_type apply_to_grid(grid_request_type r);
      grid_result_type res;
      int              w;
      int              h;
      int              idx;
      res = '0;
      w = (width_reg > MAX_COLS) ? MAX_COLS : int'(width_reg);
      h = (height_reg > MAX_ROWS) ? MAX_ROWS : int'(height_reg);
      case (r.func)
         FUNC_ALL_LIVE: foreach (grid_cells[i]) grid_cells[i] = 1'b1;
         FUNC_ALL_DEAD: foreach (grid_cells[i]) grid_cells[i] = 1'b0;
         FUNC_SET, FUNC_TOGGLE, FUNC_READ, FUNC_COUNT: begin
            if (int'(r.col) >= w || int'(r.row) >= h) begin
               res.oor = 1'b1;
            end else begin
               // The row stride follows the configured width.
               idx = int'(r.row) * w + int'(r.col);
               if (r.func == FUNC_SET) grid_cells[idx] = r.value;
               else if (r.func == FUNC_TOGGLE) grid_cells[idx] = ~grid_cells[idx];
               res.alive = grid_cells[idx];
               if (r.func == FUNC_COUNT)
                  res.count = CNT_W'(live_neighbours(int'(r.col), int'(r.row), w, h));
            end
         end
         default: ;
      endcase
      return res;
   endfunction

   // Directed table lines.
   function automatic plan_row_type plan_req(logic [FUNC_W-1:0] f, logic [COORD_W-1:0] c,
                                             logic [COORD_W-1:0] r, logic v);
      plan_row_type p;
      p = '0;
      p.req.func  = f;
      p.req.col   = c;
      p.req.row   = r;
      p.req.value = v;
      return p;
   endfunction

   function automatic plan_row_type plan_expect(logic [FUNC_W-1:0] f, logic [COORD_W-1:0] c,
                                                logic [COORD_W-1:0] r, logic v, logic alive,
                                                logic [CNT_W-1:0] count, logic oor);
      plan_row_type p;
      p = plan_req(f, c, r, v);
      p.typed       = 1'b1;
      p.given.alive = alive;
      p.given.count = count;
      p.given.oor   = oor;
      return p;
   endfunction

   function automatic plan_row_type plan_config(logic walls, logic [DIM_W-1:0] cols,
                                                logic [DIM_W-1:0] rows);
      plan_row_type p;
      p = '0;
      p.is_cfg = 1'b1;
      p.walls  = walls;
      p.cols   = cols;
      p.rows   = rows;
      return p;
   endfunction

   // Grid dimension for a random phase, with zero and oversized values now and then.
   function automatic logic [DIM_W-1:0] random_dim();
      case ($urandom_range(0, 9))
         0:       return 7'd0;
         1:       return 7'd1;
         2:       return 7'd2;
         3:       return DIM_W'($urandom_range(65, 127));
         default: return DIM_W'($urandom_range(1, 64));
      endcase
   endfunction

   // Coordinate mostly inside the grid in use, sometimes anywhere.
   function automatic logic [COORD_W-1:0] random_coord(int span);
      if (span > 0 && $urandom_range(0, 4) != 0) return COORD_W'($urandom_range(0, span - 1));
      return COORD_W'($urandom_range(0, 63));
   endfunction

   // Offers one request, waits for its transaction and records the expected response.
   task automatic send_request(input grid_request_type r, input logic typed,
                               input grid_result_type given);
      grid_result_type predicted;
      if (gap_pct != 0 && $urandom_range(1, 100) <= gap_pct) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 15)) @(posedge clock);
      end
      req_tdata  <= r;
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predicted = apply_to_grid(r);
      pending_results.push_back(typed ? given : predicted);
   endtask

   // Stops offering, waits for every outstanding response and lets the block go idle.
   task automatic settle_grid();
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Writes all three registers back to back and updates the mirror.
   task automatic write_config(input logic walls, input logic [DIM_W-1:0] cols,
                               input logic [DIM_W-1:0] rows);
      csr_we    <= 1'b1;
      csr_addr  <= CSR_WALLS;
      csr_wdata <= CSR_DATA_W'(walls);
      @(posedge clock);
      csr_addr  <= CSR_WIDTH;
      csr_wdata <= cols;
      @(posedge clock);
      csr_addr  <= CSR_HEIGHT;
      csr_wdata <= rows;
      @(posedge clock);
      csr_we     <= 1'b0;
      walls_on   = walls;
      width_reg  = cols;
      height_reg = rows;
   endtask

   // Response ready: random stall bursts and one long hold-off on request.
   initial begin : response_ready
      rsp_tready <= 1'b0;
      forever begin
         @(posedge clock);
         if (stall_hold) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            stall_hold = 1'b0;
            rsp_tready <= 1'b1;
         end else if (stall_pct != 0 && $urandom_range(1, 100) <= stall_pct) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clock);
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Response checker.
   always @(posedge clock) begin : check_responses
      grid_result_type got;
      grid_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata[5:0];
         if (pending_results.size() == 0) begin
            $error("response transaction with nothing pending, tdata %h", rsp_tdata);
            fail_count++;
         end else begin
            want = pending_results.pop_front();
            if (got.alive !== want.alive) begin
               $error("cell_alive: expected %0d, got %0d", want.alive, got.alive);
               fail_count++;
            end
            if (got.count !== want.count) begin
               $error("neighbour_count: expected %0d, got %0d", want.count, got.count);
               fail_count++;
            end
            if (got.oor !== want.oor) begin
               $error("out_of_range: expected %0d, got %0d", want.oor, got.oor);
               fail_count++;
            end
         end
      end
   end

   // Watchdog: ends the run when no transaction happens for too long.
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) quiet = 0;
         else quiet++;
      end
      $display("tb_cell_grid_neighbour_counter failed");
      $finish;
   end

   // Stimulus.
   initial begin : stimulus
      plan_row_type     plan [$];
      grid_request_type r;
      grid_result_type  none;
      int               pick;
      logic             walls;
      logic [6:0]       cols;
      logic [6:0]       rows;

      reset      <= 1'b1;
      csr_we     <= 1'b0;
      csr_addr   <= '0;
      csr_wdata  <= '0;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      none       = '0;
      fail_count = 0;
      gap_pct    = 20;
      stall_pct  = 10;
      stall_hold = 1'b0;
      walls_on   = 1'b0;
      width_reg  = 7'd64;
      height_reg = 7'd64;
      foreach (grid_cells[i]) grid_cells[i] = 1'b0;

      // Directed requests; a typed expectation only where it is obvious.
      plan = '{
         plan_expect(FUNC_READ,     6'd0,  6'd0,  1'b0, 1'b0, 4'd0, 1'b0),
         plan_expect(FUNC_SET,      6'd63, 6'd63, 1'b1, 1'b1, 4'd0, 1'b0),
         plan_expect(FUNC_READ,     6'd63, 6'd63, 1'b0, 1'b1, 4'd0, 1'b0),
         plan_req   (FUNC_COUNT,    6'd0,  6'd0,  1'b0),
         plan_expect(FUNC_SPARE_6,  6'd63, 6'd63, 1'b1, 1'b0, 4'd0, 1'b0),
         plan_expect(FUNC_SPARE_7,  6'd0,  6'd0,  1'b1, 1'b0, 4'd0, 1'b0),
         plan_expect(FUNC_ALL_LIVE, 6'd0,  6'd0,  1'b0, 1'b0, 4'd0, 1'b0),
         plan_expect(FUNC_COUNT,    6'd31, 6'd17, 1'b0, 1'b1, 4'd8, 1'b0),
         plan_expect(FUNC_SET,      6'd0,  6'd0,  1'b0, 1'b0, 4'd0, 1'b0),
         plan_req   (FUNC_COUNT,    6'd1,  6'd1,  1'b0),
         plan_expect(FUNC_ALL_DEAD, 6'd63, 6'd63, 1'b1, 1'b0, 4'd0, 1'b0),
         plan_expect(FUNC_TOGGLE,   6'd0,  6'd0,  1'b0, 1'b1, 4'd0, 1'b0),
         plan_expect(FUNC_TOGGLE,   6'd0,  6'd0,  1'b0, 1'b0, 4'd0, 1'b0),
         // Walls: nothing wraps around the corners.
         plan_config(1'b1, 7'd64, 7'd64),
         plan_expect(FUNC_SET,      6'd63, 6'd0,  1'b1, 1'b1, 4'd0, 1'b0),
         plan_req   (FUNC_COUNT,    6'd0,  6'd0,  1'b0),
         plan_req   (FUNC_COUNT,    6'd62, 6'd1,  1'b0),
         // Small grid: coordinates just past the edge are flagged.
         plan_config(1'b1, 7'd3, 7'd2),
         plan_expect(FUNC_SET,      6'd3,  6'd0,  1'b1, 1'b0, 4'd0, 1'b1),
         plan_expect(FUNC_READ,     6'd0,  6'd2,  1'b0, 1'b0, 4'd0, 1'b1),
         plan_req   (FUNC_COUNT,    6'd2,  6'd1,  1'b0),
         // Tiny torus: wrapped neighbours alias each other.
         plan_config(1'b0, 7'd3, 7'd2),
         plan_req   (FUNC_COUNT,    6'd0,  6'd0,  1'b0),
         plan_config(1'b0, 7'd1, 7'd1),
         plan_req   (FUNC_TOGGLE,   6'd0,  6'd0,  1'b0),
         plan_req   (FUNC_COUNT,    6'd0,  6'd0,  1'b0),
         // Zero width: every coordinate is out of range.
         plan_config(1'b0, 7'd0, 7'd64),
         plan_expect(FUNC_READ,     6'd0,  6'd0,  1'b0, 1'b0, 4'd0, 1'b1),
         // Oversized dimensions saturate to the maximum.
         plan_config(1'b0, 7'd127, 7'd100),
         plan_req   (FUNC_COUNT,    6'd63, 6'd63, 1'b0),
         plan_req   (FUNC_READ,     6'd63, 6'd63, 1'b0)
      };

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      foreach (plan[i]) begin
         if (plan[i].is_cfg) begin
            settle_grid();
            write_config(plan[i].walls, plan[i].cols, plan[i].rows);
         end else begin
            send_request(plan[i].req, plan[i].typed, plan[i].given);
         end
      end

      // Random phases, each under its own grid setting.
      for (int p = 0; p < NUM_PHASES; p++) begin
         settle_grid();
         if (p < PRESET_PHASES) begin
            walls = PRESET_WALLS[p];
            cols  = PRESET_COLS[p];
            rows  = PRESET_ROWS[p];
         end else begin
            walls = 1'($urandom_range(0, 1));
            cols  = random_dim();
            rows  = random_dim();
         end
         write_config(walls, cols, rows);

         // Idle bursts vary by phase; the final phase runs without any.
         if (p == NUM_PHASES - 1) begin
            gap_pct   = 0;
            stall_pct = 0;
         end else begin
            gap_pct   = 10 * $urandom_range(0, 4);
            stall_pct = 5 * $urandom_range(0, 4);
         end
         if (p == PRESSURE_PHASE) stall_hold = 1'b1;

         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 3)       r.func = ($urandom_range(0, 1) != 0) ? FUNC_ALL_LIVE
                                                                    : FUNC_ALL_DEAD;
            else if (pick < 6)  r.func = ($urandom_range(0, 1) != 0) ? FUNC_SPARE_6
                                                                    : FUNC_SPARE_7;
            else if (pick < 22) r.func = FUNC_SET;
            else if (pick < 38) r.func = FUNC_TOGGLE;
            else if (pick < 58) r.func = FUNC_READ;
            else                r.func = FUNC_COUNT;
            r.col   = random_coord((width_reg > MAX_COLS) ? MAX_COLS : int'(width_reg));
            r.row   = random_coord((height_reg > MAX_ROWS) ? MAX_ROWS : int'(height_reg));
            r.value = 1'($urandom_range(0, 1));
            send_request(r, 1'b0, none);
         end
      end

      settle_grid();
      if (fail_count == 0) begin
         $display("tb_cell_grid_neighbour_counter passed");
      end else begin
         $display("tb_cell_grid_neighbour_counter failed");
      end
      $finish;
   end

endmodule

### sim.f
rtl/core/cgnc_pkg.sv
rtl/core/cgnc_ram.sv
rtl/core/cgnc_ctrl.sv
rtl/core/cgnc_dpath.sv
rtl/core/cell_grid_neighbour_counter.sv
tb/sv/tb_cell_grid_neighbour_counter.sv
